// ===== rtl/core/ile_pkg.sv =====
// Shared constants and types for the indexed list engine.
package ile_pkg;

  // Fixed field widths of the request and response beats
  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned POS_W    = 7;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 7;

  // Operation codes
  localparam logic [OPCODE_W-1:0] OP_INS_HEAD = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_INS_TAIL = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_INS_AT   = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_READ_AT  = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_DEL_HEAD = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_DEL_TAIL = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_DEL_AT   = 3'd6;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

  // Shift command broadcast to every cell of the row
  typedef struct packed {
    logic ins;
    logic del;
  } ile_cmd_t;

endpackage

// ===== rtl/core/ile_req_if.sv =====
// Request channel: opcode, position and value with valid/ready handshake.
interface ile_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [ile_pkg::OPCODE_W-1:0]         opcode;
  logic [ile_pkg::POS_W-1:0]            position;
  logic signed [ile_pkg::VALUE_W-1:0]   item_value;

  modport source (output valid, opcode, position, item_value, input ready);
  modport sink   (input valid, opcode, position, item_value, output ready);
endinterface

// ===== rtl/core/ile_rsp_if.sv =====
// Response channel: read value, status and element count with valid/ready handshake.
interface ile_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ile_pkg::VALUE_W-1:0]   read_value;
  logic [ile_pkg::STATUS_W-1:0]         status;
  logic [ile_pkg::COUNT_W-1:0]          element_count;

  modport source (output valid, read_value, status, element_count, input ready);
  modport sink   (input valid, read_value, status, element_count, output ready);
endinterface

// ===== rtl/core/ile_cell.sv =====
// One list cell: holds one element and takes a new value, its left or right neighbor.
module ile_cell #(
  parameter int unsigned IDX       = 0,
  parameter int unsigned DATA_BITS = 32,
  parameter int unsigned CNT_W     = 7
) (
  input  logic                 clk_i,
  input  ile_pkg::ile_cmd_t    cmd_i,
  input  logic [CNT_W-1:0]     pos_i,
  input  logic [CNT_W-1:0]     count_i,
  input  logic [DATA_BITS-1:0] ins_data_i,
  input  logic [DATA_BITS-1:0] left_i,
  input  logic [DATA_BITS-1:0] right_i,
  output logic [DATA_BITS-1:0] data_o
);

  localparam logic [CNT_W-1:0] MY_IDX   = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] NEXT_IDX = CNT_W'(IDX + 1);

  logic [DATA_BITS-1:0] data_q;
  logic [DATA_BITS-1:0] data_d;

  // Pick the source for this cell from its place relative to the position
  always_comb begin
    data_d = data_q;
    if (cmd_i.ins) begin
      if (MY_IDX == pos_i) begin
        data_d = ins_data_i;
      end else if ((MY_IDX > pos_i) && (MY_IDX <= count_i)) begin
        data_d = left_i;
      end
    end else if (cmd_i.del) begin
      if ((MY_IDX >= pos_i) && (NEXT_IDX < count_i)) begin
        data_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== rtl/core/indexed_list_engine.sv =====
// Indexed list engine top level: request decode, cell row, read select and response register.
// The response beat is registered and valid in the cycle after its request beat is accepted.
// Throughput: one request per cycle while responses are taken; every operation, shifts
// included, needs no extra state because each cell of the row moves to its neighbor in parallel.
// A stalled response holds the request channel only while the response register is full.
// Reset clears the element count and the response valid; cell contents are not
// cleared, since only entries below the count are ever read.
module indexed_list_engine #(
  parameter int unsigned CAPACITY  = 64,
  parameter int unsigned DATA_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ile_req_if.sink   req_i,
  ile_rsp_if.source rsp_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CMP_W = (CNT_W > ile_pkg::POS_W) ? CNT_W : ile_pkg::POS_W;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic [CNT_W-1:0]                     count_q, count_d;
  logic                                 rsp_valid_q;
  logic signed [ile_pkg::VALUE_W-1:0]   rd_value_q, rd_value_d;
  logic [ile_pkg::STATUS_W-1:0]         status_q, status_d;
  logic [ile_pkg::COUNT_W-1:0]          count_out_q;

  logic                                 accept;
  logic [CMP_W-1:0]                     pos_c, cnt_c;
  logic                                 full, empty;
  ile_pkg::ile_cmd_t                    cmd_raw, cmd;
  logic [CNT_W-1:0]                     eff_pos;
  logic [IDX_W-1:0]                     rd_idx;
  logic [DATA_BITS-1:0]                 rd_sel;
  logic [DATA_BITS-1:0]                 ins_data;
  logic [DATA_BITS-1:0]                 cell_data [CAPACITY];

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  assign pos_c    = CMP_W'(req_i.position);
  assign cnt_c    = CMP_W'(count_q);
  assign full     = (count_q == CAP_CNT);
  assign empty    = (count_q == '0);
  assign rd_idx   = pos_c[IDX_W-1:0];
  assign ins_data = DATA_BITS'(req_i.item_value);

  // Select the addressed cell with an and-or tree
  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (IDX_W'(i) == rd_idx) begin
        rd_sel = rd_sel | cell_data[i];
      end
    end
  end

  // Decode the request into a shift command and a response
  always_comb begin
    cmd_raw    = '0;
    eff_pos    = '0;
    status_d   = ile_pkg::ST_OK;
    rd_value_d = '0;
    case (req_i.opcode)
      ile_pkg::OP_INS_HEAD: begin
        if (full) begin
          status_d = ile_pkg::ST_FULL;
        end else begin
          cmd_raw.ins = 1'b1;
        end
      end
      ile_pkg::OP_INS_TAIL: begin
        eff_pos = count_q;
        if (full) begin
          status_d = ile_pkg::ST_FULL;
        end else begin
          cmd_raw.ins = 1'b1;
        end
      end
      ile_pkg::OP_INS_AT: begin
        eff_pos = CNT_W'(pos_c);
        if (pos_c > cnt_c) begin
          status_d = ile_pkg::ST_BADPOS;
        end else if (full) begin
          status_d = ile_pkg::ST_FULL;
        end else begin
          cmd_raw.ins = 1'b1;
        end
      end
      ile_pkg::OP_READ_AT: begin
        if (pos_c >= cnt_c) begin
          status_d   = ile_pkg::ST_BADPOS;
          rd_value_d = '1;
        end else begin
          rd_value_d = ile_pkg::VALUE_W'($signed(rd_sel));
        end
      end
      ile_pkg::OP_DEL_HEAD: begin
        if (empty) begin
          status_d = ile_pkg::ST_EMPTY;
        end else begin
          cmd_raw.del = 1'b1;
        end
      end
      ile_pkg::OP_DEL_TAIL: begin
        eff_pos = count_q - CNT_W'(1);
        if (empty) begin
          status_d = ile_pkg::ST_EMPTY;
        end else begin
          cmd_raw.del = 1'b1;
        end
      end
      ile_pkg::OP_DEL_AT: begin
        eff_pos = CNT_W'(pos_c);
        if (empty) begin
          status_d = ile_pkg::ST_EMPTY;
        end else if (pos_c >= cnt_c) begin
          status_d = ile_pkg::ST_BADPOS;
        end else begin
          cmd_raw.del = 1'b1;
        end
      end
      default: begin
        status_d = ile_pkg::ST_OK;
      end
    endcase
  end

  // Gate the shift with the accepted beat
  assign cmd.ins = cmd_raw.ins && accept;
  assign cmd.del = cmd_raw.del && accept;

  always_comb begin
    count_d = count_q;
    if (cmd.ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd.del) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  // Row of cells, each handing data to its neighbors
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_BITS-1:0] left_data;
    logic [DATA_BITS-1:0] right_data;

    if (g == 0) begin : g_first
      assign left_data = '0;
    end else begin : g_inner_l
      assign left_data = cell_data[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_data = '0;
    end else begin : g_inner_r
      assign right_data = cell_data[g+1];
    end

    ile_cell #(
      .IDX       (g),
      .DATA_BITS (DATA_BITS),
      .CNT_W     (CNT_W)
    ) u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .pos_i      (eff_pos),
      .count_i    (count_q),
      .ins_data_i (ins_data),
      .left_i     (left_data),
      .right_i    (right_data),
      .data_o     (cell_data[g])
    );
  end

  // Hold the count and the response valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Load the response payload on each accepted beat
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_value_q  <= rd_value_d;
      status_q    <= status_d;
      count_out_q <= ile_pkg::COUNT_W'(count_d);
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.read_value    = rd_value_q;
  assign rsp_o.status        = status_q;
  assign rsp_o.element_count = count_out_q;

  // Count never passes capacity
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_CNT)
    else $error("element count above capacity");

  // An accepted insert grows the count by exactly one
  a_ins_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ins |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("insert did not grow the count");

  // A full status is only reported with the list at capacity
  a_full_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (status_d == ile_pkg::ST_FULL)) |=> count_q == CAP_CNT)
    else $error("full status below capacity");

  // Insert and delete never fire together
  a_cmd_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.ins && cmd.del))
    else $error("insert and delete in the same cycle");

endmodule
